// ===== hdl/lpcp_pkg.sv =====
// lpcp_pkg: shared widths, register indexes and beat/config structs for the
// lidar point camera projection pipeline. No dependencies.
`default_nettype none
package lpcp_pkg;

  localparam int PIXEL_COORD_BITS = 12;

  localparam int CAM_W   = 54;   // camera coordinates, Q.34
  localparam int PROD_W  = 52;   // rotation entry times point component
  localparam int NORM_W  = 23;   // normalized coordinates, Q.20, saturated
  localparam int Q_BITS  = 22;   // quotient bits of the depth division
  localparam int DIST_W  = 31;   // saturated distorted coordinate, Q.20
  localparam int PX_W    = 28;   // pixel index before bounds check

  localparam logic signed [CAM_W-1:0] DEPTH_CUTOFF = 54'sd42949672960; // 2.5 in Q.34

  localparam logic signed [NORM_W-1:0] NORM_MAX = 23'sh3FFFFF;
  localparam logic signed [NORM_W-1:0] NORM_MIN = 23'sh400000;

  typedef enum logic [2:0] {
    REG_ROT0       = 3'd0,
    REG_ROT1       = 3'd1,
    REG_ROT2       = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_FOCAL      = 3'd4,
    REG_PP_SIZE    = 3'd5,
    REG_RADIAL     = 3'd6,
    REG_TANGENTIAL = 3'd7
  } cfg_idx_t;

  // Per-beat control that travels alongside the payload
  typedef struct packed {
    logic valid;
    logic front;   // depth beyond cutoff
  } ctl_t;

  typedef struct packed {
    logic [59:0] rot0;
    logic [59:0] rot1;
    logic [59:0] rot2;
    logic [59:0] offset;
    logic [63:0] focal;
    logic [63:0] pp_size;
    logic [59:0] radial;
    logic [47:0] tangential;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/lpcp_xform.sv =====
// lpcp_xform: rotation and offset of one point into camera coordinates.
// Two register stages. Depends on lpcp_pkg.
`default_nettype none
module lpcp_xform (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpcp_pkg::ctl_t                       in_ctl,
  input  logic signed [31:0]                   point_x,
  input  logic signed [31:0]                   point_y,
  input  logic signed [31:0]                   point_z,
  input  lpcp_pkg::cfg_t                       cfg,
  output lpcp_pkg::ctl_t                       out_ctl,
  output logic signed [lpcp_pkg::CAM_W-1:0]    cam_x,
  output logic signed [lpcp_pkg::CAM_W-1:0]    cam_y,
  output logic signed [lpcp_pkg::CAM_W-1:0]    cam_z
);
  import lpcp_pkg::*;

  logic signed [31:0]       pt   [3];
  logic        [59:0]       rot  [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [19:0]       ofs  [3];
  logic signed [CAM_W-1:0]  cam  [3];
  ctl_t                     ctl1;

  assign pt[0]  = point_x;
  assign pt[1]  = point_y;
  assign pt[2]  = point_z;
  assign rot[0] = cfg.rot0;
  assign rot[1] = cfg.rot1;
  assign rot[2] = cfg.rot2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      out_ctl <= '0;
    end else begin
      ctl1    <= in_ctl;
      out_ctl <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      ofs[r] <= cfg.offset[20*r +: 20];
      for (int j = 0; j < 3; j++) begin
        prod[r][j] <= $signed(rot[r][20*j +: 20]) * pt[j];
      end
      // offset is Q10.10, camera frame is Q.34
      cam[r] <= {{(CAM_W-44){ofs[r][19]}}, ofs[r], 24'd0}
                + CAM_W'(prod[r][0]) + CAM_W'(prod[r][1]) + CAM_W'(prod[r][2]);
    end
  end

  assign cam_x = cam[0];
  assign cam_y = cam[1];
  assign cam_z = cam[2];

endmodule
`default_nettype wire

// ===== hdl/lpcp_divider.sv =====
// lpcp_divider: pipelined restoring division of x and y by depth, one
// quotient bit per stage, shared divisor. Depends on lpcp_pkg.
`default_nettype none
module lpcp_divider (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lpcp_pkg::ctl_t                        in_ctl,
  input  logic signed [lpcp_pkg::CAM_W-1:0]     cam_x,
  input  logic signed [lpcp_pkg::CAM_W-1:0]     cam_y,
  input  logic signed [lpcp_pkg::CAM_W-1:0]     cam_z,
  output lpcp_pkg::ctl_t                        out_ctl,
  output logic signed [lpcp_pkg::NORM_W-1:0]    norm_x,
  output logic signed [lpcp_pkg::NORM_W-1:0]    norm_y
);
  import lpcp_pkg::*;

  localparam int STEPS = Q_BITS;

  logic [CAM_W-1:0]  rem_x [STEPS+1];
  logic [CAM_W-1:0]  rem_y [STEPS+1];
  logic [CAM_W-1:0]  den   [STEPS+1];
  logic [1:0]        low_x [STEPS+1];
  logic [1:0]        low_y [STEPS+1];
  logic [Q_BITS-1:0] quo_x [STEPS+1];
  logic [Q_BITS-1:0] quo_y [STEPS+1];
  logic              neg_x [STEPS+1];
  logic              neg_y [STEPS+1];
  logic              sat_x [STEPS+1];
  logic              sat_y [STEPS+1];
  ctl_t              ctl   [STEPS+1];

  logic [CAM_W:0]    trial_x [STEPS];
  logic [CAM_W:0]    trial_y [STEPS];
  logic              ge_x    [STEPS];
  logic              ge_y    [STEPS];

  logic [CAM_W-1:0]  mag_x, mag_y;
  ctl_t              front_ctl;

  always_comb begin
    mag_x = cam_x[CAM_W-1] ? CAM_W'(0) - cam_x : cam_x;
    mag_y = cam_y[CAM_W-1] ? CAM_W'(0) - cam_y : cam_y;
    front_ctl.valid = in_ctl.valid;
    front_ctl.front = cam_z > DEPTH_CUTOFF;
  end

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      trial_x[k] = {rem_x[k], low_x[k][1]};
      trial_y[k] = {rem_y[k], low_y[k][1]};
      ge_x[k]    = trial_x[k] >= {1'b0, den[k]};
      ge_y[k]    = trial_y[k] >= {1'b0, den[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) ctl[k] <= '0;
      out_ctl <= '0;
    end else begin
      ctl[0] <= front_ctl;
      for (int k = 0; k < STEPS; k++) ctl[k+1] <= ctl[k];
      out_ctl <= ctl[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    // front: magnitudes, sign, overflow check (|num| >= 4*den saturates)
    rem_x[0] <= mag_x >> 2;
    rem_y[0] <= mag_y >> 2;
    low_x[0] <= mag_x[1:0];
    low_y[0] <= mag_y[1:0];
    den[0]   <= cam_z;
    quo_x[0] <= '0;
    quo_y[0] <= '0;
    neg_x[0] <= cam_x[CAM_W-1];
    neg_y[0] <= cam_y[CAM_W-1];
    sat_x[0] <= (mag_x >> 2) >= cam_z;
    sat_y[0] <= (mag_y >> 2) >= cam_z;
    for (int k = 0; k < STEPS; k++) begin
      rem_x[k+1] <= ge_x[k] ? CAM_W'(trial_x[k] - {1'b0, den[k]}) : trial_x[k][CAM_W-1:0];
      rem_y[k+1] <= ge_y[k] ? CAM_W'(trial_y[k] - {1'b0, den[k]}) : trial_y[k][CAM_W-1:0];
      low_x[k+1] <= {low_x[k][0], 1'b0};
      low_y[k+1] <= {low_y[k][0], 1'b0};
      quo_x[k+1] <= {quo_x[k][Q_BITS-2:0], ge_x[k]};
      quo_y[k+1] <= {quo_y[k][Q_BITS-2:0], ge_y[k]};
      den[k+1]   <= den[k];
      neg_x[k+1] <= neg_x[k];
      neg_y[k+1] <= neg_y[k];
      sat_x[k+1] <= sat_x[k];
      sat_y[k+1] <= sat_y[k];
    end
    if (sat_x[STEPS])      norm_x <= neg_x[STEPS] ? NORM_MIN : NORM_MAX;
    else if (neg_x[STEPS]) norm_x <= NORM_W'(0) - {1'b0, quo_x[STEPS]};
    else                   norm_x <= {1'b0, quo_x[STEPS]};
    if (sat_y[STEPS])      norm_y <= neg_y[STEPS] ? NORM_MIN : NORM_MAX;
    else if (neg_y[STEPS]) norm_y <= NORM_W'(0) - {1'b0, quo_y[STEPS]};
    else                   norm_y <= {1'b0, quo_y[STEPS]};
  end

endmodule
`default_nettype wire

// ===== hdl/lpcp_distort.sv =====
// lpcp_distort: radial and tangential lens distortion on normalized
// coordinates, eight register stages. Depends on lpcp_pkg.
`default_nettype none
module lpcp_distort (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lpcp_pkg::ctl_t                        in_ctl,
  input  logic signed [lpcp_pkg::NORM_W-1:0]    norm_x,
  input  logic signed [lpcp_pkg::NORM_W-1:0]    norm_y,
  input  lpcp_pkg::cfg_t                        cfg,
  output lpcp_pkg::ctl_t                        out_ctl,
  output logic signed [lpcp_pkg::DIST_W-1:0]    dist_x,
  output logic signed [lpcp_pkg::DIST_W-1:0]    dist_y
);
  import lpcp_pkg::*;

  localparam int STAGES = 8;

  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [45:0] v);
    logic signed [45:0] hi, lo;
    begin
      hi = 46'sd1073741824;
      lo = -46'sd1073741824;
      if (v >= hi)     sat_dist = {1'b0, {(DIST_W-1){1'b1}}};
      else if (v < lo) sat_dist = {1'b1, {(DIST_W-1){1'b0}}};
      else             sat_dist = v[DIST_W-1:0];
    end
  endfunction

  logic signed [19:0] k1, k2, k3;
  logic signed [23:0] p1, p2;

  assign k1 = cfg.radial[19:0];
  assign k2 = cfg.radial[39:20];
  assign k3 = cfg.radial[59:40];
  assign p1 = cfg.tangential[23:0];
  assign p2 = cfg.tangential[47:24];

  ctl_t ctl [STAGES];

  // stage 1
  logic signed [NORM_W-1:0] s1_xn, s1_yn;
  logic signed [45:0]       s1_sqx, s1_sqy, s1_xyp;
  // stage 2
  logic signed [NORM_W-1:0] s2_xn, s2_yn;
  logic        [24:0]       s2_xx, s2_yy;
  logic        [25:0]       s2_r2;
  logic signed [25:0]       s2_xy;
  logic        [45:0]       r2_sum;
  // stage 3
  logic signed [NORM_W-1:0] s3_xn, s3_yn;
  logic        [51:0]       s3_r2sq;
  logic signed [46:0]       s3_k1r2;
  logic        [26:0]       s3_ax, s3_ay;
  logic        [25:0]       s3_r2;
  logic signed [25:0]       s3_xy;
  // stage 4
  logic signed [NORM_W-1:0] s4_xn, s4_yn;
  logic        [56:0]       s4_r6p;
  logic signed [51:0]       s4_k2r4;
  logic signed [46:0]       s4_k1r2;
  logic signed [49:0]       s4_t1x, s4_t2y;
  logic signed [51:0]       s4_t2a, s4_t1a;
  logic        [30:0]       r4;
  // stage 5
  logic signed [NORM_W-1:0] s5_xn, s5_yn;
  logic signed [56:0]       s5_k3r6;
  logic signed [51:0]       s5_k2r4;
  logic signed [46:0]       s5_k1r2;
  logic signed [53:0]       s5_tx, s5_ty;
  logic        [35:0]       r6;
  // stage 6
  logic signed [NORM_W-1:0] s6_xn, s6_yn;
  logic signed [41:0]       s6_f20;
  logic signed [53:0]       s6_tx, s6_ty;
  logic signed [57:0]       f36;
  // stage 7
  logic signed [43:0]       s7_plx, s7_ply;
  logic signed [44:0]       s7_phx, s7_phy;
  logic signed [53:0]       s7_tx, s7_ty;
  logic signed [65:0]       xd, yd;

  assign r2_sum = 46'(s1_sqx[44:0]) + 46'(s1_sqy[44:0]);
  assign r4     = s3_r2sq[50:20];
  assign r6     = s4_r6p[55:20];
  assign f36    = 58'sd68719476736 + 58'(s5_k1r2) + 58'(s5_k2r4) + 58'(s5_k3r6);
  assign xd     = (66'(s7_phx) <<< 20) + 66'(s7_plx) + 66'(s7_tx);
  assign yd     = (66'(s7_phy) <<< 20) + 66'(s7_ply) + 66'(s7_ty);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) ctl[k] <= '0;
    end else begin
      ctl[0] <= in_ctl;
      for (int k = 1; k < STAGES; k++) ctl[k] <= ctl[k-1];
    end
  end

  assign out_ctl = ctl[STAGES-1];

  always_ff @(posedge clk) begin
    // squares and cross term
    s1_xn  <= norm_x;
    s1_yn  <= norm_y;
    s1_sqx <= norm_x * norm_x;
    s1_sqy <= norm_y * norm_y;
    s1_xyp <= norm_x * norm_y;
    // narrow to Q.20
    s2_xn  <= s1_xn;
    s2_yn  <= s1_yn;
    s2_xx  <= s1_sqx[44:20];
    s2_yy  <= s1_sqy[44:20];
    s2_xy  <= s1_xyp[45:20];
    s2_r2  <= r2_sum[45:20];
    // r2^2, k1 term, tangential sums
    s3_xn   <= s2_xn;
    s3_yn   <= s2_yn;
    s3_r2sq <= 52'(s2_r2) * 52'(s2_r2);
    s3_k1r2 <= k1 * $signed({1'b0, s2_r2});
    s3_ax   <= 27'(s2_r2) + 27'({s2_xx, 1'b0});
    s3_ay   <= 27'(s2_r2) + 27'({s2_yy, 1'b0});
    s3_r2   <= s2_r2;
    s3_xy   <= s2_xy;
    // r6, k2 term, tangential products
    s4_xn   <= s3_xn;
    s4_yn   <= s3_yn;
    s4_r6p  <= 57'(r4) * 57'(s3_r2);
    s4_k2r4 <= k2 * $signed({1'b0, r4});
    s4_k1r2 <= s3_k1r2;
    s4_t1x  <= p1 * s3_xy;
    s4_t2y  <= p2 * s3_xy;
    s4_t2a  <= p2 * $signed({1'b0, s3_ax});
    s4_t1a  <= p1 * $signed({1'b0, s3_ay});
    // k3 term, tangential offsets
    s5_xn   <= s4_xn;
    s5_yn   <= s4_yn;
    s5_k3r6 <= k3 * $signed({1'b0, r6});
    s5_k2r4 <= s4_k2r4;
    s5_k1r2 <= s4_k1r2;
    s5_tx   <= (54'(s4_t1x) <<< 1) + 54'(s4_t2a);
    s5_ty   <= 54'(s4_t1a) + (54'(s4_t2y) <<< 1);
    // radial factor, floor to Q.20
    s6_xn   <= s5_xn;
    s6_yn   <= s5_yn;
    s6_f20  <= f36[57:16];
    s6_tx   <= s5_tx;
    s6_ty   <= s5_ty;
    // split the wide factor into two partial products
    s7_plx  <= s6_xn * $signed({1'b0, s6_f20[19:0]});
    s7_ply  <= s6_yn * $signed({1'b0, s6_f20[19:0]});
    s7_phx  <= s6_xn * $signed(s6_f20[41:20]);
    s7_phy  <= s6_yn * $signed(s6_f20[41:20]);
    s7_tx   <= s6_tx;
    s7_ty   <= s6_ty;
    // recombine, floor to Q.20, saturate
    dist_x  <= sat_dist(xd[65:20]);
    dist_y  <= sat_dist(yd[65:20]);
  end

endmodule
`default_nettype wire

// ===== hdl/lpcp_pixel.sv =====
// lpcp_pixel: focal scaling, principal point, rounding and bounds check.
// Four register stages, the last one drives the result ports. Depends on lpcp_pkg.
`default_nettype none
module lpcp_pixel (
  input  logic                                          clk,
  input  logic                                          rst,
  input  lpcp_pkg::ctl_t                                in_ctl,
  input  logic signed [lpcp_pkg::DIST_W-1:0]            dist_x,
  input  logic signed [lpcp_pkg::DIST_W-1:0]            dist_y,
  input  lpcp_pkg::cfg_t                                cfg,
  output logic                                          done,
  output logic                                          visible,
  output logic [lpcp_pkg::PIXEL_COORD_BITS-1:0]         pixel_x,
  output logic [lpcp_pkg::PIXEL_COORD_BITS-1:0]         pixel_y
);
  import lpcp_pkg::*;

  localparam logic signed [65:0] V_HALF = 66'sd137438953472; // 0.5 in Q.38

  ctl_t ctl1, ctl2, ctl3;

  logic signed [63:0]     prod_x, prod_y;
  logic signed [65:0]     v_x, v_y;
  logic signed [PX_W-1:0] px_x, px_y;
  logic                   in_x, in_y, show;

  always_comb begin
    in_x = !px_x[PX_W-1] && ({px_x[PX_W-2:0], 4'd0} < 31'(cfg.pp_size[47:32]));
    in_y = !px_y[PX_W-1] && ({px_y[PX_W-2:0], 4'd0} < 31'(cfg.pp_size[63:48]));
    show = ctl3.front && in_x && in_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl3    <= '0;
      done    <= 1'b0;
      visible <= 1'b0;
    end else begin
      ctl1    <= in_ctl;
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      done    <= ctl3.valid;
      visible <= ctl3.valid && show;
    end
  end

  always_ff @(posedge clk) begin
    prod_x <= $signed({1'b0, cfg.focal[31:0]}) * dist_x;
    prod_y <= $signed({1'b0, cfg.focal[63:32]}) * dist_y;
    v_x    <= 66'(prod_x) + 66'({cfg.pp_size[15:0], 34'd0}) + V_HALF;
    v_y    <= 66'(prod_y) + 66'({cfg.pp_size[31:16], 34'd0}) + V_HALF;
    // truncate toward zero: floor, then bump a negative value with a fraction
    px_x   <= v_x[65:38] + PX_W'(v_x[65] & (|v_x[37:0]));
    px_y   <= v_y[65:38] + PX_W'(v_y[65] & (|v_y[37:0]));
    pixel_x <= show ? px_x[PIXEL_COORD_BITS-1:0] : '0;
    pixel_y <= show ? px_y[PIXEL_COORD_BITS-1:0] : '0;
  end

endmodule
`default_nettype wire

// ===== hdl/lidar_point_camera_projection_unit.sv =====
// lidar_point_camera_projection_unit: projects lidar points to camera pixels.
// Pipeline depth: 38 register stages from the point inputs to done.
// Throughput: one point per cycle; busy never rises, the pipeline is fully fed.
// The depth division sets the depth: 22 quotient bits, one per stage.
// Reset (rst, synchronous) clears all valid bits and every config register.
// Results cannot be stalled: each beat shows on done for exactly one cycle.
`default_nettype none
module lidar_point_camera_projection_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [31:0]                      point_x,
  input  logic signed [31:0]                      point_y,
  input  logic signed [31:0]                      point_z,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [2:0]                              cfg_index,
  input  logic [63:0]                             cfg_data,
  output logic                                    done,
  output logic                                    visible,
  output logic [lpcp_pkg::PIXEL_COORD_BITS-1:0]   pixel_x,
  output logic [lpcp_pkg::PIXEL_COORD_BITS-1:0]   pixel_y
);
  import lpcp_pkg::*;

  cfg_t cfg;
  ctl_t in_ctl, xf_ctl, dv_ctl, ds_ctl;

  logic signed [CAM_W-1:0]  cam_x, cam_y, cam_z;
  logic signed [NORM_W-1:0] norm_x, norm_y;
  logic signed [DIST_W-1:0] dist_x, dist_y;

  // Every stage advances each cycle, so a new point is always welcome.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign in_ctl.valid = start && !busy;
  assign in_ctl.front = 1'b0;

  // Configuration registers. The user must write them only while the pipe is
  // empty (the block does not enforce it), so the stages read them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_ROT0:       cfg.rot0       <= cfg_data[59:0];
        REG_ROT1:       cfg.rot1       <= cfg_data[59:0];
        REG_ROT2:       cfg.rot2       <= cfg_data[59:0];
        REG_OFFSET:     cfg.offset     <= cfg_data[59:0];
        REG_FOCAL:      cfg.focal      <= cfg_data;
        REG_PP_SIZE:    cfg.pp_size    <= cfg_data;
        REG_RADIAL:     cfg.radial     <= cfg_data[59:0];
        REG_TANGENTIAL: cfg.tangential <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Rotate and offset into the camera frame (2 stages).
  lpcp_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (in_ctl),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .cfg     (cfg),
    .out_ctl (xf_ctl),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z)
  );

  // Depth check and division by depth (24 stages).
  lpcp_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (xf_ctl),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z),
    .out_ctl (dv_ctl),
    .norm_x  (norm_x),
    .norm_y  (norm_y)
  );

  // Lens distortion (8 stages).
  lpcp_distort u_distort (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (dv_ctl),
    .norm_x  (norm_x),
    .norm_y  (norm_y),
    .cfg     (cfg),
    .out_ctl (ds_ctl),
    .dist_x  (dist_x),
    .dist_y  (dist_y)
  );

  // Focal scaling, rounding, bounds check and the result beat (4 stages).
  lpcp_pixel u_pixel (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (ds_ctl),
    .dist_x  (dist_x),
    .dist_y  (dist_y),
    .cfg     (cfg),
    .done    (done),
    .visible (visible),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y)
  );

endmodule
`default_nettype wire
